[rtl/core/occupancy_map_rectangle_query_defines.svh]
// Assertion macros shared by the block.
`ifndef OCCUPANCY_MAP_RECTANGLE_QUERY_DEFINES_SVH
`define OCCUPANCY_MAP_RECTANGLE_QUERY_DEFINES_SVH

// Same-cycle implication.
`define OMRQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("omrq assertion failed");

// Next-cycle implication.
`define OMRQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("omrq assertion failed");

`endif

[rtl/core/omrq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package omrq_pkg;

	localparam int MAX_ROWS  = 256;
	localparam int MAX_COLS  = 256;
	localparam int ROW_AW    = $clog2(MAX_ROWS);
	localparam int COL_AW    = $clog2(MAX_COLS);
	localparam int MAP_AW    = ROW_AW + COL_AW;
	localparam int MAP_DEPTH = 1 << MAP_AW;

	localparam int COORD_W = 8;
	localparam int GREY_W  = 8;
	localparam int THR_W   = 9;
	localparam logic [THR_W-1:0] THR_RESET = 9'd128;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_THRESHOLD = 1'b0;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_FLUSH  = 4'b0100,
		ST_REPORT = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;
		logic write;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic last;
	} stat_t;

endpackage
`default_nettype wire

[rtl/core/omrq_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
module omrq_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [omrq_pkg::APB_AW-1:0]   paddr,
	input  wire logic [omrq_pkg::APB_DW-1:0]   pwdata,
	output logic      [omrq_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	output logic      [omrq_pkg::THR_W-1:0]    threshold
);
	import omrq_pkg::*;

	logic [THR_W-1:0] threshold_q;
	logic             reg_sel;

	assign reg_sel   = (paddr[2] == REG_THRESHOLD);
	assign pready    = 1'b1;
	assign threshold = threshold_q;
	assign prdata    = reg_sel ? APB_DW'(threshold_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			threshold_q <= pwdata[THR_W-1:0];
		end
	end

endmodule
`default_nettype wire

[rtl/core/omrq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "occupancy_map_rectangle_query_defines.svh"
module omrq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            operation,
	input  wire omrq_pkg::stat_t stat,
	output omrq_pkg::cmd_t       cmd,
	output logic                 busy,
	output logic                 done
);
	import omrq_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_REPORT);

	always_comb begin
		cmd       = '0;
		cmd.load  = accept && (operation == OP_QUERY);
		cmd.write = accept && (operation == OP_WRITE);
		cmd.step  = (state_q == ST_SCAN);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (operation == OP_QUERY)) begin
					state_d = stat.empty ? ST_REPORT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH:  state_d = ST_REPORT;
			ST_REPORT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`OMRQ_ASSERT_NEXT(a_query_goes_busy, cmd.load, busy)
	`OMRQ_ASSERT_NEXT(a_write_stays_idle, cmd.write, !busy)
	`OMRQ_ASSERT_NEXT(a_done_one_cycle, done, !done && !busy)
	`OMRQ_ASSERT_NOW(a_cmd_exclusive, cmd.step, !cmd.load && !cmd.write)

endmodule
`default_nettype wire

[rtl/core/omrq_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module omrq_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire omrq_pkg::cmd_t                cmd,
	output omrq_pkg::stat_t                    stat,
	input  wire logic [omrq_pkg::THR_W-1:0]    threshold,
	input  wire logic [omrq_pkg::COORD_W-1:0]  pixel_row,
	input  wire logic [omrq_pkg::COORD_W-1:0]  pixel_col,
	input  wire logic [omrq_pkg::GREY_W-1:0]   grey_value,
	input  wire logic [omrq_pkg::COORD_W-1:0]  first_row,
	input  wire logic [omrq_pkg::COORD_W-1:0]  last_row,
	input  wire logic [omrq_pkg::COORD_W-1:0]  first_col,
	input  wire logic [omrq_pkg::COORD_W-1:0]  last_col,
	output logic                               any_obstacle,
	output logic                               all_obstacle
);
	import omrq_pkg::*;

	logic map_mem [MAP_DEPTH];

	logic [COORD_W-1:0] row_q, col_q, last_row_q, first_col_q, last_col_q;
	logic               any_q, all_q;
	logic               rd_valid_s1, inmap_s1, rd_data_s1;
	logic [MAP_AW-1:0]  wr_addr, rd_addr;
	logic               wr_inmap, rd_inmap, wr_obstacle;

	assign wr_inmap    = (16'(pixel_row) < 16'(MAX_ROWS)) && (16'(pixel_col) < 16'(MAX_COLS));
	assign rd_inmap    = (16'(row_q) < 16'(MAX_ROWS)) && (16'(col_q) < 16'(MAX_COLS));
	assign wr_addr     = {ROW_AW'(pixel_row), COL_AW'(pixel_col)};
	assign rd_addr     = {ROW_AW'(row_q), COL_AW'(col_q)};
	assign wr_obstacle = ({1'b0, grey_value} < threshold);

	assign stat.empty = (first_row > last_row) || (first_col > last_col);
	assign stat.last  = (row_q == last_row_q) && (col_q == last_col_q);

	assign any_obstacle = any_q;
	assign all_obstacle = all_q;

	always_ff @(posedge clk) begin
		if (cmd.write && wr_inmap) begin
			map_mem[wr_addr] <= wr_obstacle;
		end
		rd_data_s1 <= map_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		inmap_s1 <= rd_inmap;
		if (cmd.load) begin
			row_q       <= first_row;
			col_q       <= first_col;
			last_row_q  <= last_row;
			first_col_q <= first_col;
			last_col_q  <= last_col;
		end else if (cmd.step) begin
			if (col_q == last_col_q) begin
				col_q <= first_col_q;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			any_q       <= 1'b0;
			all_q       <= 1'b1;
		end else begin
			rd_valid_s1 <= cmd.step;
			if (cmd.load) begin
				any_q <= 1'b0;
				all_q <= 1'b1;
			end else if (rd_valid_s1) begin
				if (inmap_s1 && rd_data_s1) begin
					any_q <= 1'b1;
				end else begin
					all_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/occupancy_map_rectangle_query.sv]
`timescale 1ns / 1ps
`default_nettype none
// One-bit obstacle map with rectangle queries.
// Input: a transaction is taken at a clock edge with start high and busy low.
//   operation 0 writes one pixel: obstacle = grey_value below threshold.
//   It completes in the accept cycle; busy stays low and no result follows.
//   operation 1 queries the inclusive rectangle first/last row and column.
// Result: done is high for exactly one cycle with any_obstacle and
//   all_obstacle; the receiver cannot hold it off. An empty rectangle reports
//   none and all in the cycle right after the accept edge.
// Timing: a query reads one pixel per cycle from the map memory, and busy
//   stays high until done ends, so a new query or write is taken only after
//   the result of the last query. Writes sustain one per cycle while no
//   query is in progress.
// Config: APB register threshold at address 0 (9 bits); the user must write it
//   only while idle, as the block does not enforce this. pready is always high.
// Reset: threshold returns to 128; the map is not cleared and a pixel must be
//   written before a query reads it.
module occupancy_map_rectangle_query (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [omrq_pkg::APB_AW-1:0]   paddr,
	input  wire logic [omrq_pkg::APB_DW-1:0]   pwdata,
	output logic      [omrq_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          operation,
	input  wire logic [omrq_pkg::COORD_W-1:0]  pixel_row,
	input  wire logic [omrq_pkg::COORD_W-1:0]  pixel_col,
	input  wire logic [omrq_pkg::GREY_W-1:0]   grey_value,
	input  wire logic [omrq_pkg::COORD_W-1:0]  first_row,
	input  wire logic [omrq_pkg::COORD_W-1:0]  last_row,
	input  wire logic [omrq_pkg::COORD_W-1:0]  first_col,
	input  wire logic [omrq_pkg::COORD_W-1:0]  last_col,
	output logic                               done,
	output logic                               any_obstacle,
	output logic                               all_obstacle
);
	import omrq_pkg::*;

	logic [THR_W-1:0] threshold;
	cmd_t             cmd;
	stat_t            stat;

	omrq_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	omrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	omrq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.threshold    (threshold),
		.pixel_row    (pixel_row),
		.pixel_col    (pixel_col),
		.grey_value   (grey_value),
		.first_row    (first_row),
		.last_row     (last_row),
		.first_col    (first_col),
		.last_col     (last_col),
		.any_obstacle (any_obstacle),
		.all_obstacle (all_obstacle)
	);

endmodule
`default_nettype wire
